/* sv/ubct_pkg.sv */
// ----------------------------------------------------------------------------
// ubct_pkg
// Shared types and codes of the usage band crossing tracker.
// ----------------------------------------------------------------------------
package ubct_pkg;

    localparam int WORD_BITS = 32;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_BAND_STEP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_OVER  = 2'd1,
        STATUS_UNDER = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 kind;
        logic [WORD_BITS-1:0] amount;
    } req_t;

    typedef struct packed {
        logic                 band_crossed;
        status_t              status;
        logic [WORD_BITS-1:0] level_now;
        logic [WORD_BITS-1:0] band_floor_now;
    } rsp_t;

endpackage

/* sv/ubct_div.sv */
// ----------------------------------------------------------------------------
// ubct_div
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module ubct_div
    import ubct_pkg::*;
#(
    parameter int DVD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DVD_BITS-1:0]  dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] remainder
);

    localparam int CNT_BITS = (DVD_BITS > 1) ? $clog2(DVD_BITS) : 1;
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DVD_BITS - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [DVD_BITS-1:0]  dvd_reg;
    logic [WORD_BITS:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? WORD_BITS'(trial - {1'b0, divisor}) : trial[WORD_BITS-1:0];
            dvd_reg <= dvd_reg << 1;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* sv/usage_band_crossing_tracker_core.sv */
// ----------------------------------------------------------------------------
// usage_band_crossing_tracker_core
// Reserved level tracker with band crossing detection.
// ----------------------------------------------------------------------------
// Channels: req (kind, amount) in, rsp (band_crossed, status, level_now,
// band_floor_now) out, both valid/ready; cfg writes capacity (index 0) or
// band_step (index 1) and is always ready. Writing band_step restarts the
// bands at zero.
// Each req transaction gives exactly one rsp transaction. An accepted req
// is checked, then finished, where its response is loaded; with a band
// crossing the remainder search runs through the shared restoring divider
// between the two, one bit a cycle over min(LEVEL_BITS, 32) bits. One item
// is worked at a time; req_ready is high only when idle, from the cycle
// after the response is loaded, so no new req is taken before the last
// response is loaded.
// A finished response waits in its output register while the next req is
// accepted; a stalled rsp holds the block in its last step until taken.
// Reset: level and band floor zero, band step one, capacity all ones,
// no response pending.
// ----------------------------------------------------------------------------
module usage_band_crossing_tracker_core
    import ubct_pkg::*;
#(
    parameter int LEVEL_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    localparam int LW = (LEVEL_BITS < WORD_BITS) ? LEVEL_BITS : WORD_BITS;
    localparam logic [WORD_BITS-1:0] LVL_MAX = WORD_BITS'({LW{1'b1}});

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] cap_reg;
    logic [WORD_BITS-1:0] step_reg;
    logic [LW-1:0]        level_reg;
    logic [LW-1:0]        floor_reg;
    logic [WORD_BITS:0]   ceil_reg;
    logic                 kind_reg;
    logic [WORD_BITS-1:0] amount_reg;
    logic [LW-1:0]        nl_reg;
    logic                 crossed_reg;
    status_t              status_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic [WORD_BITS-1:0] step_eff;
    logic [LW-1:0]        cap_eff;
    logic [WORD_BITS:0]   add_sum;
    logic [LW-1:0]        sub_nl;
    logic                 over;
    logic                 under;
    status_t              chk_status;
    logic [LW-1:0]        chk_nl;
    logic                 need_div;
    logic [LW-1:0]        div_dvd;
    logic                 div_start;
    logic                 div_done;
    logic [WORD_BITS-1:0] div_rem;
    logic                 rsp_load;
    logic [WORD_BITS+1:0] up_t;
    logic [LW-1:0]        fin_floor;
    logic [WORD_BITS:0]   fin_ceil;

    assign step_eff = (step_reg == '0) ? WORD_BITS'(1) : step_reg;
    assign cap_eff  = (cap_reg > LVL_MAX) ? LVL_MAX[LW-1:0] : cap_reg[LW-1:0];
    assign add_sum  = (WORD_BITS+1)'(level_reg) + (WORD_BITS+1)'(amount_reg);
    assign sub_nl   = level_reg - amount_reg[LW-1:0];
    assign over     = add_sum > (WORD_BITS+1)'(cap_eff);
    assign under    = amount_reg > WORD_BITS'(level_reg);

    always_comb
    begin
        if (kind_reg == KIND_ADD)
        begin
            chk_status = over ? STATUS_OVER : STATUS_OK;
            chk_nl     = add_sum[LW-1:0];
            need_div   = !over && (add_sum >= ceil_reg);
            div_dvd    = LW'(add_sum - ceil_reg);
        end
        else
        begin
            chk_status = under ? STATUS_UNDER : STATUS_OK;
            chk_nl     = sub_nl;
            need_div   = !under && (sub_nl < floor_reg);
            div_dvd    = floor_reg - sub_nl - LW'(1);
        end
    end

    // new band from the remainder of the distance to the old band edge
    always_comb
    begin
        up_t = (WORD_BITS+2)'(nl_reg) + (WORD_BITS+2)'(div_rem) + (WORD_BITS+2)'(1);
        if (kind_reg == KIND_ADD)
        begin
            fin_floor = nl_reg - div_rem[LW-1:0];
            fin_ceil  = (WORD_BITS+1)'(nl_reg) - (WORD_BITS+1)'(div_rem)
                        + (WORD_BITS+1)'(step_eff);
        end
        else
        begin
            fin_floor = (up_t >= (WORD_BITS+2)'(step_eff))
                        ? LW'(up_t - (WORD_BITS+2)'(step_eff)) : '0;
            fin_ceil  = (WORD_BITS+1)'(fin_floor) + (WORD_BITS+1)'(step_eff);
        end
    end

    ubct_div #(
        .DVD_BITS (LW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (step_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (req_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = need_div ? ST_DIV : ST_FINISH;
            ST_DIV:    if (div_done) state_next = ST_FINISH;
            ST_FINISH: if (rsp_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        div_start = 1'b0;
        rsp_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   req_ready = 1'b1;
            ST_CHECK:  div_start = need_div;
            ST_FINISH: rsp_load  = !rsp_valid_reg || rsp_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= '1;
            step_reg      <= WORD_BITS'(1);
            level_reg     <= '0;
            floor_reg     <= '0;
            ceil_reg      <= (WORD_BITS+1)'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CAPACITY:
                    begin
                        cap_reg <= cfg_data;
                    end
                    CFG_BAND_STEP:
                    begin
                        step_reg  <= cfg_data;
                        floor_reg <= '0;
                        ceil_reg  <= (cfg_data == '0) ? (WORD_BITS+1)'(1)
                                                      : {1'b0, cfg_data};
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_CHECK && chk_status == STATUS_OK)
            begin
                level_reg <= chk_nl;
            end
            if (state_reg == ST_DIV && div_done)
            begin
                floor_reg <= fin_floor;
                ceil_reg  <= fin_ceil;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            kind_reg   <= req.kind;
            amount_reg <= req.amount;
        end
        if (state_reg == ST_CHECK)
        begin
            status_reg  <= chk_status;
            crossed_reg <= 1'b0;
            nl_reg      <= chk_nl;
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            crossed_reg <= 1'b1;
        end
        if (rsp_load)
        begin
            rsp_reg.band_crossed   <= crossed_reg;
            rsp_reg.status         <= status_reg;
            rsp_reg.level_now      <= WORD_BITS'(level_reg);
            rsp_reg.band_floor_now <= WORD_BITS'(floor_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> floor_reg <= level_reg)
        else $error("band floor above level while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        ceil_reg == (WORD_BITS+1)'(floor_reg) + (WORD_BITS+1)'(step_eff))
        else $error("band ceiling not one step above floor");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV && div_rem < step_eff)
        else $error("divider result out of place or out of range");

endmodule

/* sim/usage_band_crossing_tracker_core_test.sv */
// ----------------------------------------------------------------------------
// usage_band_crossing_tracker_core_test
// Self-checking testbench for the usage band crossing tracker.
// ----------------------------------------------------------------------------
// Drives add and remove transactions through the req channel and works out
// each response in a band ledger that mirrors the level, band floor and band
// ceiling. Responses are checked field by field in order. A directed run
// covers the range ends, refusals, zero step, lowered capacity and band
// restarts; random phases follow under varied capacity and step settings,
// with random gaps on both channels, one long response stall and one pause
// of the sender until every response is back.
// ----------------------------------------------------------------------------
module usage_band_crossing_tracker_core_test;
    import ubct_pkg::*;

    localparam int LEVEL_BITS = 32;

    class band_ledger;
        int          level_bits;
        logic [31:0] capacity;
        logic [31:0] band_step;
        logic [63:0] level;
        logic [63:0] band_floor;
        logic [63:0] band_ceiling;
        rsp_t        pending_results[$];
        int unsigned mismatches;
        int unsigned items;
        int unsigned results;
        int unsigned crossings;
        int unsigned overs;
        int unsigned unders;
        int unsigned writes;

        function new(int bits);
            level_bits   = bits;
            capacity     = 32'hFFFF_FFFF;
            band_step    = 32'd1;
            level        = 64'd0;
            band_floor   = 64'd0;
            band_ceiling = 64'd1;
            mismatches   = 0;
            items        = 0;
            results      = 0;
            crossings    = 0;
            overs        = 0;
            unders       = 0;
            writes       = 0;
        endfunction

        function logic [63:0] eff_step();
            return (band_step == 32'd0) ? 64'd1 : {32'd0, band_step};
        endfunction

        function logic [63:0] cap_limit();
            logic [63:0] lvl_max;
            lvl_max = (64'd1 << level_bits) - 64'd1;
            return ({32'd0, capacity} > lvl_max) ? lvl_max : {32'd0, capacity};
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function void write_register(logic idx, logic [31:0] value);
            writes++;
            if (idx == CFG_CAPACITY)
                capacity = value;
            else
            begin
                band_step    = value;
                band_floor   = 64'd0;
                band_ceiling = eff_step();
            end
        endfunction

        function void note_request(req_t r);
            logic [63:0] stp;
            logic [63:0] nl;
            logic [63:0] k;
            logic [63:0] drop;
            rsp_t        e;
            stp            = eff_step();
            e.band_crossed = 1'b0;
            e.status       = STATUS_OK;
            items++;
            if (r.kind == KIND_ADD)
            begin
                nl = level + {32'd0, r.amount};
                if (nl > cap_limit())
                    e.status = STATUS_OVER;
                else
                begin
                    level = nl;
                    if (nl >= band_ceiling)
                    begin
                        k              = (nl - band_ceiling) / stp + 64'd1;
                        band_ceiling   = band_ceiling + k * stp;
                        band_floor     = band_ceiling - stp;
                        e.band_crossed = 1'b1;
                    end
                end
            end
            else if ({32'd0, r.amount} > level)
                e.status = STATUS_UNDER;
            else
            begin
                nl    = level - {32'd0, r.amount};
                level = nl;
                if (nl < band_floor)
                begin
                    k              = (band_floor - nl - 64'd1) / stp + 64'd1;
                    drop           = k * stp;
                    band_floor     = (drop > band_floor) ? 64'd0 : band_floor - drop;
                    band_ceiling   = band_floor + stp;
                    e.band_crossed = 1'b1;
                end
            end
            if (e.band_crossed)
                crossings++;
            if (e.status == STATUS_OVER)
                overs++;
            if (e.status == STATUS_UNDER)
                unders++;
            e.level_now      = level[31:0];
            e.band_floor_now = band_floor[31:0];
            pending_results.push_back(e);
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            results++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("response %0d arrived with nothing outstanding",
                                 results));
                return;
            end
            want = pending_results.pop_front();
            if (got.band_crossed !== want.band_crossed)
                report($sformatf("response %0d band_crossed %0b, expected %0b",
                                 results, got.band_crossed, want.band_crossed));
            if (got.status !== want.status)
                report($sformatf("response %0d status %0d, expected %0d",
                                 results, got.status, want.status));
            if (got.level_now !== want.level_now)
                report($sformatf("response %0d level_now %h, expected %h",
                                 results, got.level_now, want.level_now));
            if (got.band_floor_now !== want.band_floor_now)
                report($sformatf("response %0d band_floor_now %h, expected %h",
                                 results, got.band_floor_now, want.band_floor_now));
        endtask

        task close_out();
            if (pending_results.size() != 0)
                report($sformatf("%0d responses never arrived", pending_results.size()));
        endtask
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 req_valid   = 1'b0;
    logic                 req_ready;
    req_t                 req         = '0;
    logic                 rsp_valid;
    logic                 rsp_ready   = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index   = CFG_CAPACITY;
    logic [WORD_BITS-1:0] cfg_data    = '0;

    band_ledger           ledger;
    logic                 tx_idle_on  = 1'b1;
    logic                 rx_idle_on  = 1'b1;
    logic                 rx_hold_req = 1'b0;
    int                   rx_wait     = 0;

    usage_band_crossing_tracker_core #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // response side: random gaps, and a long hold when asked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                ledger.check_result(rsp);
                rx_wait = rx_idle_on ? $urandom_range(5) : 0;
            end
            else if (rx_wait != 0)
            begin
                rx_wait = rx_wait - 1;
            end
            if (rx_hold_req)
            begin
                rx_wait     = 300;
                rx_hold_req = 1'b0;
            end
            rsp_ready <= (rx_wait == 0);
        end
    end

    function automatic logic [63:0] lesser(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [31:0] draw_upto(input logic [63:0] hi);
        return (hi >= 64'hFFFF_FFFF) ? $urandom : $urandom_range(hi[31:0]);
    endfunction

    task automatic send_item(input logic kind, input logic [31:0] amount);
        int gap;
        gap = tx_idle_on ? $urandom_range(5) : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{kind: kind, amount: amount};
        do @(posedge clk); while (!req_ready);
        ledger.note_request(req);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (ledger.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic quiesce();
        settle();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        ledger.write_register(idx, value);
    endtask

    task automatic write_regs(input logic cap_en, input logic [31:0] cap,
                              input logic step_en, input logic [31:0] step);
        if (cap_en)
            write_reg(CFG_CAPACITY, cap);
        if (step_en)
            write_reg(CFG_BAND_STEP, step);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [63:0] stp;
        logic [63:0] room;
        logic [63:0] lvl;
        logic [31:0] cap_w;
        logic [31:0] step_w;
        logic        wr_step;
        logic        kind;
        logic [31:0] amount;
        int          ph;
        int          n;
        ledger = new(LEVEL_BITS);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: capacity all ones, step one
        send_item(KIND_ADD, 32'd0);
        send_item(KIND_ADD, 32'd1);
        send_item(KIND_ADD, 32'hFFFF_FFFE);
        send_item(KIND_ADD, 32'd0);
        send_item(KIND_ADD, 32'd1);
        send_item(KIND_ADD, 32'hFFFF_FFFF);
        send_item(KIND_REMOVE, 32'hFFFF_FFFF);
        send_item(KIND_REMOVE, 32'd1);
        send_item(KIND_REMOVE, 32'd0);
        // zero step behaves as one
        quiesce();
        write_regs(1'b1, 32'd1000, 1'b1, 32'd0);
        send_item(KIND_ADD, 32'd5);
        send_item(KIND_ADD, 32'd995);
        send_item(KIND_ADD, 32'd1);
        // band restart with the level above the new ceiling
        quiesce();
        write_regs(1'b0, 32'd0, 1'b1, 32'd100);
        send_item(KIND_REMOVE, 32'd810);
        send_item(KIND_ADD, 32'd0);
        send_item(KIND_REMOVE, 32'd91);
        send_item(KIND_ADD, 32'd101);
        // capacity lowered under the level
        quiesce();
        write_regs(1'b1, 32'd150, 1'b0, 32'd0);
        send_item(KIND_ADD, 32'd0);
        send_item(KIND_REMOVE, 32'd50);
        quiesce();
        write_regs(1'b1, 32'd0, 1'b0, 32'd0);
        send_item(KIND_REMOVE, 32'd150);
        send_item(KIND_ADD, 32'd0);
        send_item(KIND_ADD, 32'd1);
        // widest step
        quiesce();
        write_regs(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(KIND_ADD, 32'hFFFF_FFFE);
        send_item(KIND_ADD, 32'd1);
        send_item(KIND_REMOVE, 32'd1);
        send_item(KIND_REMOVE, 32'hFFFF_FFFE);

        for (ph = 0; ph < 9; ph++)
        begin
            quiesce();
            cap_w   = 32'hFFFF_FFFF;
            step_w  = 32'd1;
            wr_step = 1'b1;
            case (ph)
                0: ;
                1:
                begin
                    cap_w  = 32'd20000;
                    step_w = 32'd0;
                end
                2:
                begin
                    cap_w  = 32'd100000;
                    step_w = $urandom_range(2000, 50);
                end
                default:
                begin
                    case ($urandom_range(3))
                        0:       cap_w = 32'hFFFF_FFFF;
                        1:       cap_w = $urandom;
                        2:       cap_w = $urandom_range(5000, 1);
                        default: cap_w = $urandom_range(300);
                    endcase
                    case ($urandom_range(5))
                        0:       step_w = 32'd0;
                        1:       step_w = 32'd1;
                        2:       step_w = $urandom_range(64, 2);
                        3:       step_w = cap_w / $urandom_range(20, 2);
                        4:       step_w = $urandom;
                        default: step_w = 32'hFFFF_FFFF;
                    endcase
                    wr_step = (ph == 3) || ($urandom_range(2) != 0);
                end
            endcase
            write_regs(1'b1, cap_w, wr_step, step_w);
            tx_idle_on = (ph % 3 != 1);
            rx_idle_on = (ph % 4 != 2);

            for (n = 0; n < 103; n++)
            begin
                if (ph == 2 && n == 30)
                    rx_hold_req = 1'b1;
                if (ph == 5 && n == 50)
                    settle();
                stp  = ledger.eff_step();
                lvl  = ledger.level;
                room = (lvl > ledger.cap_limit()) ? 64'd0 : ledger.cap_limit() - lvl;
                kind = KIND_ADD;
                case ($urandom_range(19))
                    0, 1, 2, 3, 4:
                        amount = draw_upto(lesser(64'd2 * stp, room));
                    5, 6:
                        amount = draw_upto(room);
                    7:
                        amount = room[31:0];
                    8:
                        amount = (ledger.band_ceiling > lvl)
                               ? 32'(ledger.band_ceiling - lvl) : 32'd0;
                    9:
                        amount = (room < 64'hFFFF_FFFF)
                               ? 32'(room + 64'd1
                                     + 64'(draw_upto(lesser(stp, 64'hFFFF_FFFE - room))))
                               : $urandom;
                    10, 11, 12, 13, 14:
                    begin
                        kind   = KIND_REMOVE;
                        amount = draw_upto(lesser(64'd2 * stp, lvl));
                    end
                    15:
                    begin
                        kind   = KIND_REMOVE;
                        amount = draw_upto(lvl);
                    end
                    16:
                    begin
                        // just under the current floor
                        kind   = KIND_REMOVE;
                        amount = (ledger.band_floor != 0)
                               ? 32'(lvl - ledger.band_floor + 64'd1) : lvl[31:0];
                    end
                    17:
                    begin
                        kind   = KIND_REMOVE;
                        amount = lvl[31:0];
                    end
                    18:
                    begin
                        kind   = KIND_REMOVE;
                        amount = (lvl < 64'hFFFF_FFFF)
                               ? 32'(lvl + 64'd1
                                     + 64'(draw_upto(lesser(stp, 64'hFFFF_FFFE - lvl))))
                               : $urandom;
                    end
                    default:
                    begin
                        kind   = 1'($urandom_range(1));
                        amount = $urandom;
                    end
                endcase
                send_item(kind, amount);
            end
        end

        settle();
        repeat (40) @(posedge clk);
        ledger.close_out();
        $display("Ran %0d transactions: %0d band crossings, %0d refused over capacity,",
                 ledger.items, ledger.crossings, ledger.overs);
        $display("%0d refused below zero, %0d register writes, %0d responses checked",
                 ledger.unders, ledger.writes, ledger.results);
        if (ledger.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
